// File: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/i2cee_pkg.sv
`default_nettype none

package i2cee_pkg;

	localparam int ADDR_W   = 11;
	localparam int LEN_W    = 12;
	localparam int DEV_W    = 7;
	localparam int WORD_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;

	localparam int PAGE_BYTES = 16;
	localparam int MEM_BYTES  = 2048;
	localparam int PAGE_W     = $clog2(PAGE_BYTES);
	localparam int CHUNK_W    = $clog2(PAGE_BYTES + 1);

	localparam logic [DEV_W-1:0] DEVICE_BASE_RST = DEV_W'(80);
	localparam logic [LEN_W-1:0] BYTE_SIZE_RST   = LEN_W'(2048);

	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SIZE   = 1'b1;

	typedef enum logic [1:0] {
		CMD_RD   = 2'd0,
		CMD_WR   = 2'd1,
		CMD_DONE = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_RD   = 2'd0,
		KIND_WR   = 2'd1,
		KIND_DONE = 2'd2,
		KIND_REJ  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BUSY     = 3'd1,
		ST_RD_RANGE = 3'd2,
		ST_WR_RANGE = 3'd3,
		ST_BUS_ERR  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_READ = 4'b0010,
		MODE_WRITE = 4'b0100,
		MODE_POLL = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  cur;
		logic [LEN_W-1:0]   left;
		logic [ADDR_W-1:0]  off;
		logic [CHUNK_W-1:0] chunk;
	} job_t;

	typedef struct packed {
		kind_t             kind;
		logic [DEV_W-1:0]  dev;
		logic [WORD_W-1:0] word;
		logic [ADDR_W-1:0] off;
		logic [LEN_W-1:0]  len;
		status_t           status;
	} res_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic              err;
	} item_t;

endpackage

`default_nettype wire

// File: rtl/core/i2cee_step.sv
`default_nettype none

// One sequencer step: job state and one item in, next job state and at most one result out.
module i2cee_step
	import i2cee_pkg::*;
(
	input  wire item_t            item,
	input  wire job_t             st,
	input  wire [DEV_W-1:0]       device_base,
	input  wire [LEN_W-1:0]       byte_size,
	output job_t                  st_nxt,
	output res_t                  res,
	output logic                  has_res
);

	function automatic logic [DEV_W-1:0] dev_for(input logic [DEV_W-1:0] base,
			input logic [ADDR_W-1:0] a);
		return DEV_W'(base + DEV_W'(a[ADDR_W-1:WORD_W]));
	endfunction

	job_t               nc_src;
	logic [CHUNK_W-1:0] page_room;
	logic [CHUNK_W-1:0] chunk;
	logic [LEN_W-1:0]   limit;
	logic               out_of_range;
	logic               do_chunk;
	res_t               res_zero;

	always_comb begin
		limit = (byte_size < LEN_W'(MEM_BYTES)) ? byte_size : LEN_W'(MEM_BYTES);
		out_of_range = ((LEN_W+1)'(item.addr) + (LEN_W+1)'(item.len)) > (LEN_W+1)'(limit);

		res_zero = '{kind: KIND_DONE, dev: '0, word: '0, off: '0, len: '0, status: ST_OK};

		// source state for the next-chunk decision: a fresh write job or a finished poll
		nc_src = st;
		if (item.cmd == CMD_WR) begin
			nc_src.cur   = item.addr;
			nc_src.left  = item.len;
			nc_src.off   = '0;
			nc_src.chunk = '0;
		end else begin
			nc_src.cur  = ADDR_W'(st.cur + ADDR_W'(st.chunk));
			nc_src.off  = ADDR_W'(st.off + ADDR_W'(st.chunk));
			nc_src.left = (LEN_W'(st.chunk) > st.left) ? '0 : st.left - LEN_W'(st.chunk);
		end

		page_room = CHUNK_W'(PAGE_BYTES) - CHUNK_W'(nc_src.cur[PAGE_W-1:0]);
		chunk = (nc_src.left < LEN_W'(page_room)) ? CHUNK_W'(nc_src.left) : page_room;

		st_nxt   = st;
		res      = res_zero;
		has_res  = 1'b0;
		do_chunk = 1'b0;

		unique case (item.cmd)
			CMD_RD, CMD_WR: begin
				has_res = 1'b1;
				res.kind = KIND_REJ;
				if (st.mode != MODE_IDLE) begin
					res.status = ST_BUSY;
				end else if (out_of_range) begin
					res.status = (item.cmd == CMD_RD) ? ST_RD_RANGE : ST_WR_RANGE;
				end else if (item.cmd == CMD_RD) begin
					st_nxt.mode  = MODE_READ;
					st_nxt.cur   = item.addr;
					st_nxt.left  = item.len;
					st_nxt.off   = '0;
					st_nxt.chunk = '0;
					res.kind     = KIND_RD;
					res.dev      = dev_for(device_base, item.addr);
					res.word     = item.addr[WORD_W-1:0];
					res.len      = item.len;
				end else begin
					do_chunk = 1'b1;
				end
			end
			CMD_DONE: begin
				unique case (st.mode)
					MODE_READ: begin
						has_res     = 1'b1;
						st_nxt.mode = MODE_IDLE;
						res.status  = item.err ? ST_BUS_ERR : ST_OK;
					end
					MODE_WRITE: begin
						has_res = 1'b1;
						if (item.err) begin
							st_nxt.mode = MODE_IDLE;
							res.status  = ST_BUS_ERR;
						end else begin
							st_nxt.mode = MODE_POLL;
							res.kind    = KIND_RD;
							res.dev     = device_base;
							res.len     = LEN_W'(1);
						end
					end
					MODE_POLL: begin
						has_res = 1'b1;
						if (item.err) begin
							res.kind = KIND_RD;
							res.dev  = device_base;
							res.len  = LEN_W'(1);
						end else begin
							do_chunk = 1'b1;
						end
					end
					default: begin
						// done while idle: dropped
					end
				endcase
			end
			default: begin
				// no-op command
			end
		endcase

		if (do_chunk) begin
			st_nxt = nc_src;
			if (nc_src.left == '0) begin
				// nothing left (or an empty write): job completes
				st_nxt.mode = MODE_IDLE;
				res.kind    = KIND_DONE;
			end else begin
				st_nxt.mode  = MODE_WRITE;
				st_nxt.chunk = chunk;
				res.kind     = KIND_WR;
				res.dev      = dev_for(device_base, nc_src.cur);
				res.word     = nc_src.cur[WORD_W-1:0];
				res.off      = nc_src.off;
				res.len      = LEN_W'(chunk);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/i2c_eeprom_page_write_sequencer.sv
`default_nettype none

// Page-write sequencer for a small I2C EEPROM with 11-bit byte addresses.
// Input channel (in_valid/in_ready): commands start read, start write, and
// bus transaction finished (with bus_error). Output channel (out_valid/
// out_ready): bus read/write requests, job completions and start rejections;
// each input transaction gives zero or one output transaction.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 device_base,
// index 1 byte_size; write only while no job is in flight.
// A result passes through the input register, then the result register; the
// step between the two registers is combinational. Throughput: one transaction
// per cycle while a low out_ready does not hold the result register (see Stall).
// Write jobs are split at 16-byte page edges; after each chunk written without
// bus_error the block issues 1-byte poll reads until one completes without bus_error.
// Reset: no job, output empty, device_base = 80, byte_size = 2048.
// Stall: while out_valid is held by a low out_ready, the input register
// keeps one more transaction and in_ready drops after that; nothing is lost.
module i2c_eeprom_page_write_sequencer
	import i2cee_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// input channel
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire [1:0]              command,
	input  wire [ADDR_W-1:0]       start_address,
	input  wire [LEN_W-1:0]        length,
	input  wire                    bus_error,
	// output channel
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [1:0]             result_kind,
	output logic [DEV_W-1:0]       device_address,
	output logic [WORD_W-1:0]      word_address,
	output logic [ADDR_W-1:0]      buffer_offset,
	output logic [LEN_W-1:0]       transfer_length,
	output logic [2:0]             status,
	// configuration channel
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire [CFG_IDX_W-1:0]    cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data
);

	// input register
	logic  vld_s1;
	item_t item_s1;

	// job state and config
	job_t             job_q;
	logic [DEV_W-1:0] device_base_q;
	logic [LEN_W-1:0] byte_size_q;

	// result register
	logic out_valid_q;
	res_t res_q;

	job_t job_nxt;
	res_t res_nxt;
	logic has_res;
	logic advance;

	// s1 moves on whenever the result slot is free or draining this cycle
	assign advance   = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !vld_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{cmd: cmd_t'(command), addr: start_address, len: length,
				err: bus_error};
		end
	end

	i2cee_step u_step (
		.item        (item_s1),
		.st          (job_q),
		.device_base (device_base_q),
		.byte_size   (byte_size_q),
		.st_nxt      (job_nxt),
		.res         (res_nxt),
		.has_res     (has_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '{mode: MODE_IDLE, cur: '0, left: '0, off: '0, chunk: '0};
		end else if (advance) begin
			job_q <= job_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_base_q <= DEVICE_BASE_RST;
			byte_size_q   <= BYTE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEVICE_BASE: device_base_q <= cfg_data[DEV_W-1:0];
				CFG_BYTE_SIZE:   byte_size_q   <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = res_q.kind;
	assign device_address  = res_q.dev;
	assign word_address    = res_q.word;
	assign buffer_offset   = res_q.off;
	assign transfer_length = res_q.len;
	assign status          = res_q.status;

endmodule

`default_nettype wire

// File: rtl/core/i2cee_checker.sv
`default_nettype none

`include "assert_macros.svh"

module i2cee_checker
	import i2cee_pkg::*;
(
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_ready,
	input wire [1:0]          result_kind,
	input wire [DEV_W-1:0]    device_address,
	input wire [WORD_W-1:0]   word_address,
	input wire [ADDR_W-1:0]   buffer_offset,
	input wire [LEN_W-1:0]    transfer_length,
	input wire [2:0]          status
);

	// a stalled result holds
	`CHK_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(transfer_length) && $stable(status), "output changed while stalled")

	// bus requests always carry ok status
	`CHK_ASSERT(a_req_ok, clk, arst_n, out_valid && (result_kind == KIND_RD || result_kind == KIND_WR) |-> status == ST_OK, "bus request with non-ok status")

	// completions and rejections carry no addressing
	`CHK_ASSERT(a_end_zero, clk, arst_n, out_valid && (result_kind == KIND_DONE || result_kind == KIND_REJ) |-> device_address == '0 && word_address == '0 && buffer_offset == '0 && transfer_length == '0, "completion with addressing")

	// a chunk write is never empty and never crosses a page
	`CHK_ASSERT(a_chunk_page, clk, arst_n, out_valid && result_kind == KIND_WR |-> transfer_length != '0 && ((LEN_W+1)'(word_address[PAGE_W-1:0]) + (LEN_W+1)'(transfer_length)) <= (LEN_W+1)'(PAGE_BYTES), "chunk crosses page")

	// an edge seen in reset leaves nothing offered on the next one
	`CHK_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid, "output valid after reset")

endmodule

bind i2c_eeprom_page_write_sequencer i2cee_checker u_i2cee_checker (.*);

`default_nettype wire
